// ----- design/pgh_pkg.sv -----
// ----------------------------------------------------------------------------
// pgh_pkg
// Shared types, widths, codes and reset values of the pressure gauge block.
// ----------------------------------------------------------------------------
`default_nettype none

package pgh_pkg;

    // history ring and bar geometry (ring depth is a power of two)
    localparam int HISTORY_DEPTH = 128;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int BAR_WIDTH     = 128;
    localparam int BAR_BITS      = $clog2(BAR_WIDTH + 1);

    // field widths
    localparam int ADC_W   = 10;
    localparam int SCALE_W = 16;
    localparam int P_W     = 14;
    localparam int GT_W    = 6;
    localparam int GH_W    = 6;
    localparam int IDX_W   = 7;
    localparam int LVL_W   = 2;
    localparam int BAR_W   = 8;
    localparam int COLX_W  = 8;
    localparam int ROW_W   = 7;

    // signed product of (adc - zero) and the scale, with headroom for the offset
    localparam int PROD_W  = ADC_W + 1 + SCALE_W + 1;

    // shared divider: dividend is pressure * BAR_WIDTH or entry * graph height
    localparam int DIVD_W  = (P_W + BAR_BITS > P_W + GH_W) ? P_W + BAR_BITS : P_W + GH_W;
    localparam int CNT_W   = $clog2(DIVD_W + 1);

    localparam logic [P_W-1:0] P_MAX = {P_W{1'b1}};

    // configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    localparam logic [CFG_AW-1:0] CFG_ADC_ZERO     = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_SCALE_Q8     = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_ATMOS_OFFSET = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_IDLE_LIMIT   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_HIGH_LIMIT   = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_GRAPH_TOP    = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_GRAPH_HEIGHT = 3'd6;

    // register reset values
    localparam logic [ADC_W-1:0]   RST_ADC_ZERO     = 10'd102;
    localparam logic [SCALE_W-1:0] RST_SCALE_Q8     = 16'd4376;
    localparam logic [P_W-1:0]     RST_ATMOS_OFFSET = 14'd1470;
    localparam logic [P_W-1:0]     RST_IDLE_LIMIT   = 14'd7000;
    localparam logic [P_W-1:0]     RST_HIGH_LIMIT   = 14'd11000;
    localparam logic [GT_W-1:0]    RST_GRAPH_TOP    = 6'd32;
    localparam logic [GH_W-1:0]    RST_GRAPH_HEIGHT = 6'd31;

    // item commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COLUMN = 1'b1;

    // level classes
    localparam logic [LVL_W-1:0] LEVEL_IDLE   = 2'd0;
    localparam logic [LVL_W-1:0] LEVEL_NORMAL = 2'd1;
    localparam logic [LVL_W-1:0] LEVEL_HIGH   = 2'd2;

    typedef struct packed {
        logic             cmd;
        logic [ADC_W-1:0] adc_sample;
        logic [IDX_W-1:0] column_index;
    } in_item_t;

    typedef struct packed {
        logic [P_W-1:0]    pressure;
        logic [LVL_W-1:0]  level;
        logic [P_W-1:0]    peak;
        logic [BAR_W-1:0]  bar_length;
        logic [COLX_W-1:0] column_x;
        logic [ROW_W-1:0]  top_row;
        logic [ROW_W-1:0]  span;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CLAMP,
        ST_STORE,
        ST_READ,
        ST_FETCH,
        ST_DIV,
        ST_OUT
    } pgh_state_t;

endpackage

`default_nettype wire

// ----- design/pressure_gauge_history_graph_top.sv -----
// ----------------------------------------------------------------------------
// pressure_gauge_history_graph_top
// Pressure gauge with peak, level class, bar length and sparkline history.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries items: cmd 0 is a converter sample, cmd 1 asks for one
//   sparkline column at column_index, 1 being the newest sample, 2 the one before.
//   m_* returns one result beat per item: pressure, level, peak and bar
//   length always, column fields for column items (zero for samples).
//   cfg_* writes a register by index; it is always ready and is to be used
//   only while no item is in flight.
// Sequence:
//   a sample passes multiply, clamp, store, 22 divide steps plus one to take
//   the quotient, and the output load; a column item passes ram read and fetch
//   instead of multiply, clamp and store. The shared 22-step divider is the
//   longest part; s_ready is low while an item is being worked on and returns
//   in the cycle after the result is loaded, so the block takes no new item
//   before it is through with the last one.
// Reset:
//   registers return to their defaults, history reads as zero, peak is zero.
// Stall:
//   a result waits in the output register; the next item is taken and worked
//   on meanwhile and its result holds until the register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_gauge_history_graph_top (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire pgh_pkg::in_item_t          s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output pgh_pkg::out_item_t              m_data,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [pgh_pkg::CFG_AW-1:0] cfg_addr,
    input  wire logic [pgh_pkg::CFG_DW-1:0] cfg_data
);

    import pgh_pkg::*;

    // configuration registers
    logic [ADC_W-1:0]   adc_zero_reg;
    logic [SCALE_W-1:0] scale_q8_reg;
    logic [P_W-1:0]     atmos_offset_reg;
    logic [P_W-1:0]     idle_limit_reg;
    logic [P_W-1:0]     high_limit_reg;
    logic [GT_W-1:0]    graph_top_reg;
    logic [GH_W-1:0]    graph_height_reg;

    // sequencer and item state
    pgh_state_t         state_reg, state_next;
    in_item_t           item_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [P_W-1:0]     p_reg;
    logic [P_W-1:0]     last_p_reg;
    logic [P_W-1:0]     peak_reg;
    logic [BAR_W-1:0]   bar_reg;
    logic [GH_W-1:0]    q_reg;
    logic               dzero_reg;
    logic [HIST_AW-1:0] wp_reg;
    logic [HISTORY_DEPTH-1:0] hvld_reg;
    logic               rvld_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    // sequencer outputs
    logic               item_take;
    logic               mul_en;
    logic               clamp_en;
    logic               store_en;
    logic               read_en;
    logic               fetch_en;
    logic               div_take;
    logic               out_load;

    // datapath nets
    logic signed [ADC_W:0]    diff_s;
    logic signed [PROD_W-1:0] acc_s;
    logic [P_W-1:0]     p_clamped;
    logic [P_W-1:0]     peak_new;
    logic [HIST_AW-1:0] rd_addr;
    logic [P_W-1:0]     ram_rdata;
    logic [P_W-1:0]     entry;
    logic               div_start;
    logic [DIVD_W-1:0]  div_dividend;
    logic [P_W-1:0]     div_divisor;
    logic               div_done;
    logic [DIVD_W-1:0]  div_quo;
    logic [BAR_W-1:0]   bar_sat;
    logic [GH_W-1:0]    q_sat;
    logic [LVL_W-1:0]   level_now;
    out_item_t          result;

    assign cfg_ready = 1'b1;

    // configuration writes, unknown indexes dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adc_zero_reg     <= RST_ADC_ZERO;
            scale_q8_reg     <= RST_SCALE_Q8;
            atmos_offset_reg <= RST_ATMOS_OFFSET;
            idle_limit_reg   <= RST_IDLE_LIMIT;
            high_limit_reg   <= RST_HIGH_LIMIT;
            graph_top_reg    <= RST_GRAPH_TOP;
            graph_height_reg <= RST_GRAPH_HEIGHT;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                CFG_ADC_ZERO:     adc_zero_reg     <= cfg_data[ADC_W-1:0];
                CFG_SCALE_Q8:     scale_q8_reg     <= cfg_data[SCALE_W-1:0];
                CFG_ATMOS_OFFSET: atmos_offset_reg <= cfg_data[P_W-1:0];
                CFG_IDLE_LIMIT:   idle_limit_reg   <= cfg_data[P_W-1:0];
                CFG_HIGH_LIMIT:   high_limit_reg   <= cfg_data[P_W-1:0];
                CFG_GRAPH_TOP:    graph_top_reg    <= cfg_data[GT_W-1:0];
                CFG_GRAPH_HEIGHT: graph_height_reg <= cfg_data[GH_W-1:0];
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and step enables
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        item_take  = 1'b0;
        mul_en     = 1'b0;
        clamp_en   = 1'b0;
        store_en   = 1'b0;
        read_en    = 1'b0;
        fetch_en   = 1'b0;
        div_take   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_take  = 1'b1;
                    state_next = (s_data.cmd == CMD_SAMPLE) ? ST_MUL : ST_READ;
                end
            end
            ST_MUL: begin
                mul_en     = 1'b1;
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                clamp_en   = 1'b1;
                state_next = ST_STORE;
            end
            ST_STORE: begin
                store_en   = 1'b1;
                state_next = ST_DIV;
            end
            ST_READ: begin
                read_en    = 1'b1;
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                fetch_en   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    div_take   = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // scaling: (adc - zero) * scale - offset * 256, then shift and clamp
    always_comb begin
        diff_s = $signed({1'b0, item_reg.adc_sample}) - $signed({1'b0, adc_zero_reg});
        acc_s  = prod_reg - $signed({{(PROD_W - P_W - 8){1'b0}}, atmos_offset_reg, 8'd0});
        if (acc_s <= 0) begin
            p_clamped = '0;
        end else if (|acc_s[PROD_W-1:P_W+8]) begin
            p_clamped = P_MAX;
        end else begin
            p_clamped = acc_s[P_W+7:8];
        end
        peak_new = (p_reg > peak_reg) ? p_reg : peak_reg;
    end

    // history lookup address and entry, unwritten entries read as zero
    assign rd_addr = item_reg.column_index[HIST_AW-1:0] + wp_reg;
    assign entry   = rvld_reg ? ram_rdata : '0;

    // divider operands: bar from a sample, column height from a lookup
    always_comb begin
        div_start    = store_en || fetch_en;
        div_dividend = DIVD_W'(entry) * DIVD_W'(graph_height_reg);
        div_divisor  = peak_reg;
        if (store_en) begin
            div_dividend = DIVD_W'(p_reg) * DIVD_W'(BAR_WIDTH);
            div_divisor  = peak_new;
        end
    end

    // quotient saturation
    always_comb begin
        bar_sat = (|div_quo[DIVD_W-1:BAR_W]) ? {BAR_W{1'b1}} : div_quo[BAR_W-1:0];
        q_sat   = (div_quo > DIVD_W'(graph_height_reg)) ? graph_height_reg : div_quo[GH_W-1:0];
    end

    // control state of the item path
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg     <= HIST_AW'(HISTORY_DEPTH - 1);
            hvld_reg   <= '0;
            peak_reg   <= '0;
            last_p_reg <= '0;
            bar_reg    <= '0;
        end else if (store_en) begin
            wp_reg           <= (wp_reg == '0) ? HIST_AW'(HISTORY_DEPTH - 1) : wp_reg - 1'b1;
            hvld_reg[wp_reg] <= 1'b1;
            peak_reg         <= peak_new;
            last_p_reg       <= p_reg;
        end else if (div_take && item_reg.cmd == CMD_SAMPLE) begin
            bar_reg <= dzero_reg ? '0 : bar_sat;
        end
    end

    // item payload registers
    always_ff @(posedge aclk) begin
        if (item_take) begin
            item_reg <= s_data;
        end
        if (mul_en) begin
            prod_reg <= PROD_W'(diff_s * $signed({1'b0, scale_q8_reg}));
        end
        if (clamp_en) begin
            p_reg <= p_clamped;
        end
        if (read_en) begin
            rvld_reg <= hvld_reg[rd_addr];
        end
        if (store_en) begin
            dzero_reg <= (peak_new == '0);
        end else if (fetch_en) begin
            dzero_reg <= (peak_reg == '0);
        end
        if (div_take && item_reg.cmd == CMD_COLUMN) begin
            q_reg <= dzero_reg ? '0 : q_sat;
        end
    end

    // history ring
    pgh_ram #(
        .WIDTH (P_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .aclk  (aclk),
        .we    (store_en),
        .waddr (wp_reg),
        .wdata (p_reg),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // shared divider
    pgh_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // result assembly
    always_comb begin
        if (last_p_reg < idle_limit_reg) begin
            level_now = LEVEL_IDLE;
        end else if (last_p_reg < high_limit_reg) begin
            level_now = LEVEL_NORMAL;
        end else begin
            level_now = LEVEL_HIGH;
        end
        result            = '0;
        result.pressure   = last_p_reg;
        result.level      = level_now;
        result.peak       = peak_reg;
        result.bar_length = bar_reg;
        if (item_reg.cmd == CMD_COLUMN) begin
            result.column_x = COLX_W'(BAR_WIDTH) - COLX_W'(item_reg.column_index);
            result.top_row  = ROW_W'(graph_top_reg) + ROW_W'(graph_height_reg)
                            - ROW_W'(q_reg);
            result.span     = (q_reg != '0) ? ROW_W'(q_reg) + ROW_W'(1) : ROW_W'(1);
        end
    end

    // output register, holds a beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ----- design/pgh_ram.sv -----
// ----------------------------------------------------------------------------
// pgh_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pgh_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/pgh_div.sv -----
// ----------------------------------------------------------------------------
// pgh_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pgh_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [pgh_pkg::DIVD_W-1:0] dividend,
    input  wire logic [pgh_pkg::P_W-1:0]    divisor,
    output logic                            done,
    output logic      [pgh_pkg::DIVD_W-1:0] quotient
);

    import pgh_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [P_W-1:0]    rem_reg;
    logic [P_W-1:0]    dvs_reg;
    logic [DIVD_W-1:0] quo_reg;

    logic [P_W:0]      shifted;
    logic              ge;
    logic [P_W:0]      diff;
    logic [P_W-1:0]    rem_next;
    logic [DIVD_W-1:0] quo_next;

    // one trial subtraction per cycle
    always_comb begin
        shifted  = {rem_reg, quo_reg[DIVD_W-1]};
        ge       = shifted >= {1'b0, dvs_reg};
        diff     = shifted - {1'b0, dvs_reg};
        rem_next = ge ? diff[P_W-1:0] : shifted[P_W-1:0];
        quo_next = {quo_reg[DIVD_W-2:0], ge};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIVD_W);
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != CNT_W'(1));
            done_reg <= (cnt_reg == CNT_W'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire
